@@ sv/ots_pkg.sv @@
`default_nettype none
package ots_pkg;

  // Field widths of one input word and one result word.
  localparam int SLOT_W     = 4;
  localparam int TIME_W     = 62;
  localparam int DELTA_W    = 63;
  localparam int SLOT_RANGE = 16;

  // Command codes carried in the input word.
  typedef enum logic [1:0] {
    CMD_START_ABS   = 2'd0,
    CMD_START_DELTA = 2'd1,
    CMD_STOP        = 2'd2,
    CMD_RUN         = 2'd3
  } cmd_e_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;      // write an expiry, append the slot if it is new
    logic stop;       // drop the addressed slot from the order
    logic run_init;   // latch now and rewind the scan
    logic fire;       // report the scanned slot as expired and remove it
    logic keep;       // scanned slot stays pending: fold into minimum, step on
    logic emit_done;  // load the final next-deadline word
  } ots_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_end;     // scan index has reached the order count
    logic expired;    // scanned slot expires strictly before now
    logic out_free;   // output register can take a word this cycle
  } ots_sts_t;

endpackage
`default_nettype wire

@@ sv/ots_ctrl.sv @@
`default_nettype none
module ots_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ots_pkg::cmd_e_t in_cmd,
  input  wire ots_pkg::ots_sts_t sts,
  output ots_pkg::ots_ctl_t    ctl
);
  import ots_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t state;
  logic   accept;

  // Items are taken only between runs.
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Command decode and scan stepping.
  always_comb begin
    ctl           = '0;
    ctl.start     = accept && ((in_cmd == CMD_START_ABS) || (in_cmd == CMD_START_DELTA));
    ctl.stop      = accept && (in_cmd == CMD_STOP);
    ctl.run_init  = accept && (in_cmd == CMD_RUN);
    if (state == ST_SCAN) begin
      ctl.fire      = !sts.at_end && sts.expired && sts.out_free;
      ctl.keep      = !sts.at_end && !sts.expired;
      ctl.emit_done = sts.at_end && sts.out_free;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (ctl.run_init) state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (ctl.emit_done) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/ots_dpath.sv @@
`default_nettype none
module ots_dpath #(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire ots_pkg::ots_ctl_t            ctl,
  output ots_pkg::ots_sts_t                 sts,
  input  wire logic                         in_delta,
  input  wire logic [ots_pkg::SLOT_W-1:0]   in_slot,
  input  wire logic [ots_pkg::TIME_W-1:0]   in_time,
  input  wire logic [ots_pkg::TIME_W-1:0]   in_now,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_is_expiry,
  output logic [ots_pkg::SLOT_W-1:0]        out_fired_slot,
  output logic signed [ots_pkg::DELTA_W-1:0] out_next_delta,
  output logic                              out_last
);
  import ots_pkg::*;

  // Only slots that the slot field can address get storage.
  localparam int DEPTH = (NUM_SLOTS < SLOT_RANGE) ? NUM_SLOTS : SLOT_RANGE;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [TIME_W-1:0] expiry_time [DEPTH];
  logic [IDX_W-1:0]  start_order [DEPTH];
  logic [DEPTH-1:0]  pending;
  logic [CNT_W-1:0]  count;

  logic [CNT_W-1:0]  idx;
  logic              found;
  logic [TIME_W-1:0] best;
  logic [TIME_W-1:0] now_q;

  logic              slot_ok;
  logic [IDX_W-1:0]  slot_idx;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] exp_new;
  logic [IDX_W-1:0]  cur_slot;
  logic [TIME_W-1:0] cur_exp;
  logic [DEPTH-1:0]  stop_hit;
  logic [DEPTH-1:0]  rm_mask;
  logic              do_append;
  logic              do_stop;
  logic              do_shift;

  // Start operand: absolute expiry, or now plus delta saturated to the time range.
  assign slot_ok  = (32'(in_slot) < DEPTH);
  assign slot_idx = IDX_W'(in_slot);
  assign sum      = {1'b0, in_now} + {1'b0, in_time};
  assign exp_new  = !in_delta ? in_time : (sum[TIME_W] ? '1 : sum[TIME_W-1:0]);

  assign do_append = ctl.start && slot_ok && !pending[slot_idx] && (count < CNT_W'(DEPTH));
  assign do_stop   = ctl.stop && slot_ok && pending[slot_idx];
  assign do_shift  = do_stop || ctl.fire;

  // Scan lookup: order entry at the scan index, then its expiry.
  assign cur_slot = start_order[idx[IDX_W-1:0]];
  assign cur_exp  = expiry_time[cur_slot];

  assign sts.at_end   = (idx == count);
  assign sts.expired  = (cur_exp < now_q);
  assign sts.out_free = !out_valid || out_ready;

  // Entries from the removed position upward move down by one.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      stop_hit[i] = (CNT_W'(i) < count) && (start_order[i] == slot_idx);
    end
    for (int i = 0; i < DEPTH; i++) begin
      rm_mask[i] = 1'b0;
      if (ctl.fire) begin
        rm_mask[i] = (CNT_W'(i) >= idx);
      end else begin
        for (int j = 0; j <= i; j++) begin
          rm_mask[i] = rm_mask[i] | stop_hit[j];
        end
      end
    end
  end

  // Expiry store.
  always_ff @(posedge clk) begin
    if (ctl.start && slot_ok) expiry_time[slot_idx] <= exp_new;
  end

  // Start order store: append on a new start, compact on a removal.
  always_ff @(posedge clk) begin
    if (do_append) start_order[count[IDX_W-1:0]] <= slot_idx;
    if (do_shift) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (rm_mask[i]) start_order[i] <= start_order[i + 1];
      end
    end
  end

  // Pending marks, order count, scan state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      count     <= '0;
      idx       <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (do_append) begin
        pending[slot_idx] <= 1'b1;
        count             <= count + 1'b1;
      end
      if (do_stop) begin
        pending[slot_idx] <= 1'b0;
        count             <= count - 1'b1;
      end
      if (ctl.fire) begin
        pending[cur_slot] <= 1'b0;
        count             <= count - 1'b1;
      end
      if (ctl.run_init) begin
        idx   <= '0;
        found <= 1'b0;
      end
      if (ctl.keep) begin
        idx   <= idx + 1'b1;
        found <= 1'b1;
      end
      // Rewind the scan index once the run is over, so stops cannot leave it past the end.
      if (ctl.emit_done) begin
        idx <= '0;
      end
      if (ctl.fire || ctl.emit_done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Run payload: latched now, running minimum and output word.
  always_ff @(posedge clk) begin
    if (ctl.run_init) now_q <= in_now;
    if (ctl.keep && (!found || (cur_exp < best))) best <= cur_exp;
    if (ctl.fire) begin
      out_is_expiry  <= 1'b1;
      out_fired_slot <= SLOT_W'(cur_slot);
      out_next_delta <= '0;
      out_last       <= 1'b0;
    end else if (ctl.emit_done) begin
      out_is_expiry  <= 1'b0;
      out_fired_slot <= '0;
      out_next_delta <= found ? $signed({1'b0, best - now_q}) : '1;
      out_last       <= 1'b1;
    end
  end

  // The order holds exactly the pending slots.
  a_count_matches_marks: assert property (@(posedge clk) disable iff (rst)
    $countones(pending) == 32'(count))
    else $error("order count differs from number of pending slots");

  // A word is only loaded when the output register can take it.
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.fire || ctl.emit_done) |-> sts.out_free)
    else $error("output word loaded while previous word still held");

  // Each fired slot leaves the order.
  a_fire_shrinks: assert property (@(posedge clk) disable iff (rst)
    ctl.fire |=> (count == $past(count) - 1'b1))
    else $error("fired slot not removed from the order");

  // The scan index never passes the end of the order.
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    idx <= count)
    else $error("scan index beyond order count");

endmodule
`default_nettype wire

@@ sv/one_shot_timer_bank.sv @@
`default_nettype none
// Bank of one-shot timers with slots kept in start order. A start or stop word
// is taken and gives no result. A run word scans the started slots in order,
// one order entry per cycle while the output side does not stall, through a
// single expiry compare; each slot that expires before now is reported and
// removed, then one final word gives the time to the earliest remaining expiry
// (-1 when none is pending). The next input word is taken in the cycle after
// the final word is loaded. No new input word is taken while a run is in
// progress; the output register lets the next word enter while the last result
// still waits. Reset needs no clearing pass.
module one_shot_timer_bank #(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [135:0] s_axis_tdata,   // cmd, slot, time_value, now, zero pad
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [71:0]       m_axis_tdata,   // fired_slot, next_delta, zero pad
  output logic              m_axis_tuser,   // is_expiry
  output logic              m_axis_tlast
);
  import ots_pkg::*;

  ots_ctl_t                  ctl;
  ots_sts_t                  sts;
  cmd_e_t                    in_cmd;
  logic [SLOT_W-1:0]         fired_slot;
  logic signed [DELTA_W-1:0] next_delta;

  // Input word fields.
  assign in_cmd = cmd_e_t'(s_axis_tdata[1:0]);

  ots_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_cmd   (in_cmd),
    .sts      (sts),
    .ctl      (ctl)
  );

  ots_dpath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .sts            (sts),
    .in_delta       (in_cmd == CMD_START_DELTA),
    .in_slot        (s_axis_tdata[5:2]),
    .in_time        (s_axis_tdata[67:6]),
    .in_now         (s_axis_tdata[129:68]),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_is_expiry  (m_axis_tuser),
    .out_fired_slot (fired_slot),
    .out_next_delta (next_delta),
    .out_last       (m_axis_tlast)
  );

  // Result word packing.
  assign m_axis_tdata = {5'd0, next_delta, fired_slot};

endmodule
`default_nettype wire
